// File: rtl/core/mfbre_pkg.sv
package mfbre_pkg;

    localparam int DEF_COLUMNS = 128;
    localparam int DEF_PAGES   = 8;

    typedef enum logic [2:0] {
        MODE_CLEAR,
        MODE_PIXEL,
        MODE_LINE,
        MODE_RECT,
        MODE_FILL_RECT,
        MODE_CIRCLE,
        MODE_FILL_CIRCLE,
        MODE_READ
    } t_mode;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_CLR,
        DP_LINE_LOAD,
        DP_SPAN_LOAD,
        DP_PIX_RD,
        DP_PIX_WR,
        DP_CIRC_STEP,
        DP_ROW_INC,
        DP_RD_ISSUE,
        DP_RES_READ,
        DP_RES_ZERO
    } t_dp_op;

    typedef logic [3:0] t_sel;

    // line sources
    localparam t_sel LN_RECT_TOP   = 4'd0;
    localparam t_sel LN_RECT_BOT   = 4'd1;
    localparam t_sel LN_RECT_LEFT  = 4'd2;
    localparam t_sel LN_RECT_RIGHT = 4'd3;
    localparam t_sel LN_SEG        = 4'd4;
    localparam t_sel LN_ROW        = 4'd5;

    // span sources: circle points, trailing point, fill spans, single pixel
    localparam t_sel PT_FIRST = 4'd0;
    localparam t_sel PT_LAST  = 4'd8;
    localparam t_sel PT_TRAIL = 4'd9;
    localparam t_sel SP_FIRST = 4'd10;
    localparam t_sel SP_LAST  = 4'd13;
    localparam t_sel SP_PIXEL = 4'd14;

    typedef struct packed {
        t_dp_op op;
        t_sel   sel;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_last;
        logic clr_last;
        logic row_done;
        logic circ_run;
    } t_dp_stat;

endpackage

// File: rtl/core/mfbre_ctrl.sv
module mfbre_ctrl
    import mfbre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic [2:0] i_mode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy,
    output logic     o_done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_LINE_LOAD,
        S_SPAN_LOAD,
        S_PIX_RD,
        S_PIX_WR,
        S_NEXT,
        S_ROW_CHECK,
        S_CIRC_CHECK,
        S_CIRC_STEP,
        S_READ,
        S_RES_READ,
        S_RES
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    t_sel   r_sel, n_sel;
    logic   r_cmd_clr, n_cmd_clr;
    logic   r_done, n_done;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_sel     = r_sel;
        n_cmd_clr = r_cmd_clr;
        n_done    = 1'b0;
        o_cmd.op  = DP_NOP;
        o_cmd.sel = r_sel;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLR;
                if (i_stat.clr_last) begin
                    n_state   = r_cmd_clr ? S_RES : S_IDLE;
                    n_cmd_clr = 1'b0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = DP_LATCH;
                    n_mode   = t_mode'(i_mode);
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_mode)
                    MODE_CLEAR: begin
                        n_cmd_clr = 1'b1;
                        n_state   = S_CLEAR;
                    end
                    MODE_PIXEL: begin
                        n_sel   = SP_PIXEL;
                        n_state = S_SPAN_LOAD;
                    end
                    MODE_LINE: begin
                        n_sel   = LN_SEG;
                        n_state = S_LINE_LOAD;
                    end
                    MODE_RECT: begin
                        n_sel   = LN_RECT_TOP;
                        n_state = S_LINE_LOAD;
                    end
                    MODE_FILL_RECT: begin
                        n_sel   = LN_ROW;
                        n_state = S_ROW_CHECK;
                    end
                    MODE_CIRCLE, MODE_FILL_CIRCLE: begin
                        n_state = S_CIRC_CHECK;
                    end
                    MODE_READ: begin
                        n_state = S_READ;
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_LINE_LOAD: begin
                o_cmd.op = DP_LINE_LOAD;
                n_state  = S_PIX_RD;
            end
            S_SPAN_LOAD: begin
                o_cmd.op = DP_SPAN_LOAD;
                n_state  = S_PIX_RD;
            end
            S_PIX_RD: begin
                o_cmd.op = DP_PIX_RD;
                n_state  = S_PIX_WR;
            end
            S_PIX_WR: begin
                o_cmd.op = DP_PIX_WR;
                n_state  = i_stat.walk_last ? S_NEXT : S_PIX_RD;
            end
            S_NEXT: begin
                case (r_mode)
                    MODE_RECT: begin
                        if (r_sel == LN_RECT_RIGHT) begin
                            n_state = S_RES;
                        end else begin
                            n_sel   = t_sel'(r_sel + 1'b1);
                            n_state = S_LINE_LOAD;
                        end
                    end
                    MODE_FILL_RECT: begin
                        o_cmd.op = DP_ROW_INC;
                        n_state  = S_ROW_CHECK;
                    end
                    MODE_CIRCLE: begin
                        if (r_sel == PT_LAST) begin
                            n_state = S_CIRC_STEP;
                        end else if (r_sel == PT_TRAIL) begin
                            n_state = S_CIRC_CHECK;
                        end else begin
                            n_sel   = t_sel'(r_sel + 1'b1);
                            n_state = S_SPAN_LOAD;
                        end
                    end
                    MODE_FILL_CIRCLE: begin
                        if (r_sel == SP_LAST) begin
                            n_state = S_CIRC_STEP;
                        end else begin
                            n_sel   = t_sel'(r_sel + 1'b1);
                            n_state = S_SPAN_LOAD;
                        end
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_CIRC_STEP: begin
                o_cmd.op = DP_CIRC_STEP;
                if (r_mode == MODE_CIRCLE) begin
                    n_sel   = PT_TRAIL;
                    n_state = S_SPAN_LOAD;
                end else begin
                    n_state = S_CIRC_CHECK;
                end
            end
            S_ROW_CHECK: begin
                n_state = i_stat.row_done ? S_RES : S_LINE_LOAD;
            end
            S_CIRC_CHECK: begin
                if (i_stat.circ_run) begin
                    n_sel   = (r_mode == MODE_CIRCLE) ? PT_FIRST : SP_FIRST;
                    n_state = S_SPAN_LOAD;
                end else begin
                    n_state = S_RES;
                end
            end
            S_READ: begin
                o_cmd.op = DP_RD_ISSUE;
                n_state  = S_RES_READ;
            end
            S_RES_READ: begin
                o_cmd.op = DP_RES_READ;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_RES: begin
                o_cmd.op = DP_RES_ZERO;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_mode    <= MODE_CLEAR;
            r_sel     <= LN_RECT_TOP;
            r_cmd_clr <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_sel     <= n_sel;
            r_cmd_clr <= n_cmd_clr;
            r_done    <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// File: rtl/core/mfbre_dpath.sv
module mfbre_dpath
    import mfbre_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_end_x,
    input  logic [7:0] i_end_y,
    input  logic       i_ink_clear,
    output t_dp_stat   o_stat,
    output logic [7:0] o_read_data,
    output logic       o_off_screen
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic [7:0] x, input logic [7:0] y);
        logic [15:0] lin;
        lin = 16'(y[7:3]) * 16'(COLUMNS) + 16'(x);
        return lin[AW-1:0];
    endfunction

    function automatic logic f_on_screen(input logic [7:0] x, input logic [7:0] y);
        return ({1'b0, x} < 9'(COLUMNS)) && ({1'b0, y} < 9'(PAGES * 8));
    endfunction

    logic [7:0] r_mem [DEPTH];

    logic [7:0] r_px, r_py, r_ex, r_ey;
    logic       r_ink;
    logic [7:0] r_row;

    logic signed [9:0]  r_ca, r_cb;
    logic signed [13:0] r_cd;

    logic [7:0]         r_wx, r_wy;
    logic [8:0]         r_cnt;
    logic signed [10:0] r_err;
    logic [7:0]         r_dmaj, r_dmin;
    logic               r_smaj_neg, r_smin_neg, r_xmaj, r_bres;

    logic [AW-1:0] r_addr;
    logic          r_pix_ok;
    logic [2:0]    r_bit;
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic [7:0]    r_res_data;
    logic          r_res_off;

    // line source and setup
    logic [7:0] ex_sum, ey_sum, row_y;
    logic [7:0] lx1, ly1, lx2, ly2, adx, ady;
    logic [7:0] l_x, l_y, l_dmaj, l_dmin;
    logic [8:0] l_cnt;
    logic       l_xmaj, l_bres, l_smaj_neg, l_smin_neg;

    always_comb begin
        ex_sum = r_px + r_ex;
        ey_sum = r_py + r_ey;
        row_y  = r_py + r_row;
        case (i_cmd.sel)
            LN_RECT_TOP: begin
                lx1 = r_px;   ly1 = r_py;   lx2 = ex_sum; ly2 = r_py;
            end
            LN_RECT_BOT: begin
                lx1 = r_px;   ly1 = ey_sum; lx2 = ex_sum; ly2 = ey_sum;
            end
            LN_RECT_LEFT: begin
                lx1 = r_px;   ly1 = r_py;   lx2 = r_px;   ly2 = ey_sum;
            end
            LN_RECT_RIGHT: begin
                lx1 = ex_sum; ly1 = r_py;   lx2 = ex_sum; ly2 = ey_sum;
            end
            LN_ROW: begin
                lx1 = r_px;   ly1 = row_y;  lx2 = ex_sum; ly2 = row_y;
            end
            default: begin
                lx1 = r_px;   ly1 = r_py;   lx2 = r_ex;   ly2 = r_ey;
            end
        endcase

        adx = (lx2 > lx1) ? (lx2 - lx1) : (lx1 - lx2);
        ady = (ly2 > ly1) ? (ly2 - ly1) : (ly1 - ly2);

        l_x        = lx1;
        l_y        = ly1;
        l_dmaj     = 8'd0;
        l_dmin     = 8'd0;
        l_smaj_neg = 1'b0;
        l_smin_neg = 1'b0;
        l_xmaj     = 1'b1;
        l_bres     = 1'b0;
        if (lx1 == lx2) begin
            l_y    = (ly1 < ly2) ? ly1 : ly2;
            l_cnt  = {1'b0, ady} + 9'd1;
            l_xmaj = 1'b0;
        end else if (ly1 == ly2) begin
            l_x   = (lx1 < lx2) ? lx1 : lx2;
            l_cnt = {1'b0, adx} + 9'd1;
        end else begin
            l_bres = 1'b1;
            if (adx > ady) begin
                l_dmaj     = adx;
                l_dmin     = ady;
                l_smaj_neg = (lx2 < lx1);
                l_smin_neg = (ly2 < ly1);
                l_cnt      = {1'b0, adx};
            end else begin
                l_xmaj     = 1'b0;
                l_dmaj     = ady;
                l_dmin     = adx;
                l_smaj_neg = (ly2 < ly1);
                l_smin_neg = (lx2 < lx1);
                l_cnt      = {1'b0, ady};
            end
        end
    end

    // circle point and span source
    logic [7:0] a8, b8, s_x, s_y;
    logic [8:0] s_cnt;

    always_comb begin
        a8    = r_ca[7:0];
        b8    = r_cb[7:0];
        s_cnt = 9'd1;
        case (i_cmd.sel)
            4'd0:     begin s_x = r_px - b8; s_y = r_py - a8; end
            4'd1:     begin s_x = r_px + b8; s_y = r_py - a8; end
            4'd2:     begin s_x = r_px - a8; s_y = r_py + b8; end
            4'd3:     begin s_x = r_px - b8; s_y = r_py - a8; end
            4'd4:     begin s_x = r_px - a8; s_y = r_py - b8; end
            4'd5:     begin s_x = r_px + b8; s_y = r_py + a8; end
            4'd6:     begin s_x = r_px + a8; s_y = r_py - b8; end
            4'd7:     begin s_x = r_px + a8; s_y = r_py + b8; end
            PT_LAST:  begin s_x = r_px - b8; s_y = r_py + a8; end
            PT_TRAIL: begin s_x = r_px + a8; s_y = r_py + b8; end
            SP_FIRST: begin
                s_x = r_px - b8; s_y = r_py + a8; s_cnt = {b8, 1'b1};
            end
            4'd11: begin
                s_x = r_px - b8; s_y = r_py - a8; s_cnt = {b8, 1'b1};
            end
            4'd12: begin
                s_x = r_px - a8; s_y = r_py + b8; s_cnt = {a8, 1'b1};
            end
            SP_LAST: begin
                s_x = r_px - a8; s_y = r_py - b8; s_cnt = {a8, 1'b1};
            end
            default:  begin s_x = r_px; s_y = r_py; end
        endcase
    end

    // walker advance
    logic [7:0]         maj, mino, n_maj, n_min, n_wx, n_wy;
    logic signed [10:0] e1, n_err;
    logic               step_min;

    always_comb begin
        maj      = r_xmaj ? r_wx : r_wy;
        mino     = r_xmaj ? r_wy : r_wx;
        n_maj    = maj + (r_smaj_neg ? 8'hFF : 8'h01);
        e1       = r_err + $signed({3'b000, r_dmin});
        step_min = r_bres && ($signed({e1, 1'b0}) >= $signed({4'b0000, r_dmaj}));
        n_min    = step_min ? (mino + (r_smin_neg ? 8'hFF : 8'h01)) : mino;
        n_err    = step_min ? (e1 - $signed({3'b000, r_dmaj})) : e1;
        n_wx     = r_xmaj ? n_maj : n_min;
        n_wy     = r_xmaj ? n_min : n_maj;
    end

    // circle update
    logic signed [9:0]  n_ca, n_cb;
    logic signed [13:0] n_cd;

    always_comb begin
        n_ca = r_ca + 10'sd1;
        if (r_cd < 0) begin
            n_cd = r_cd + (14'(n_ca) <<< 2) + 14'sd6;
            n_cb = r_cb;
        end else begin
            n_cd = r_cd + 14'sd10 + (14'(n_ca - r_cb) <<< 2);
            n_cb = r_cb - 10'sd1;
        end
    end

    // memory port
    logic [7:0]    rd_x, rd_y, mask, mem_wdata;
    logic          rd_op, rd_ok, mem_we;
    logic [AW-1:0] mem_waddr;

    always_comb begin
        rd_op     = (i_cmd.op == DP_PIX_RD) || (i_cmd.op == DP_RD_ISSUE);
        rd_x      = (i_cmd.op == DP_RD_ISSUE) ? r_px : r_wx;
        rd_y      = (i_cmd.op == DP_RD_ISSUE) ? r_py : r_wy;
        rd_ok     = f_on_screen(rd_x, rd_y);
        mask      = 8'd1 << r_bit;
        mem_we    = (i_cmd.op == DP_CLR) || ((i_cmd.op == DP_PIX_WR) && r_pix_ok);
        mem_waddr = (i_cmd.op == DP_CLR) ? r_clr_addr : r_addr;
        if (i_cmd.op == DP_CLR) begin
            mem_wdata = 8'd0;
        end else if (r_ink) begin
            mem_wdata = r_rdata & ~mask;
        end else begin
            mem_wdata = r_rdata | mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_op && rd_ok) begin
            r_rdata <= r_mem[f_addr(rd_x, rd_y)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.op == DP_CLR) begin
            r_clr_addr <= o_stat.clr_last ? '0 : AW'(r_clr_addr + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_px  <= i_pos_x;
                r_py  <= i_pos_y;
                r_ex  <= i_end_x;
                r_ey  <= i_end_y;
                r_ink <= i_ink_clear;
                r_row <= 8'd0;
                r_ca  <= 10'sd0;
                r_cb  <= $signed({2'b00, i_end_x});
                r_cd  <= 14'sd3 - $signed({5'b00000, i_end_x, 1'b0});
            end
            DP_LINE_LOAD: begin
                r_wx       <= l_x;
                r_wy       <= l_y;
                r_cnt      <= l_cnt;
                r_err      <= 11'sd0;
                r_dmaj     <= l_dmaj;
                r_dmin     <= l_dmin;
                r_smaj_neg <= l_smaj_neg;
                r_smin_neg <= l_smin_neg;
                r_xmaj     <= l_xmaj;
                r_bres     <= l_bres;
            end
            DP_SPAN_LOAD: begin
                r_wx       <= s_x;
                r_wy       <= s_y;
                r_cnt      <= s_cnt;
                r_err      <= 11'sd0;
                r_dmaj     <= 8'd0;
                r_dmin     <= 8'd0;
                r_smaj_neg <= 1'b0;
                r_smin_neg <= 1'b0;
                r_xmaj     <= 1'b1;
                r_bres     <= 1'b0;
            end
            DP_PIX_RD, DP_RD_ISSUE: begin
                r_addr   <= f_addr(rd_x, rd_y);
                r_pix_ok <= rd_ok;
                r_bit    <= rd_y[2:0];
            end
            DP_PIX_WR: begin
                r_wx  <= n_wx;
                r_wy  <= n_wy;
                r_err <= n_err;
                r_cnt <= r_cnt - 9'd1;
            end
            DP_CIRC_STEP: begin
                r_ca <= n_ca;
                r_cb <= n_cb;
                r_cd <= n_cd;
            end
            DP_ROW_INC: begin
                r_row <= r_row + 8'd1;
            end
            DP_RES_READ: begin
                r_res_data <= r_pix_ok ? r_rdata : 8'd0;
                r_res_off  <= ~r_pix_ok;
            end
            DP_RES_ZERO: begin
                r_res_data <= 8'd0;
                r_res_off  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.walk_last = (r_cnt == 9'd1);
    assign o_stat.clr_last  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.row_done  = (r_row == r_ey);
    assign o_stat.circ_run  = (r_ca <= r_cb);
    assign o_read_data      = r_res_data;
    assign o_off_screen     = r_res_off;

endmodule

// File: rtl/core/mono_frame_buffer_raster_engine_top.sv
// Raster engine for a one-bit, page-organized frame store of COLUMNS x PAGES*8 pixels.
// A command is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with o_done high, and it must be taken then: there is no stall.
// o_read_data/o_off_screen carry the byte read back by mode 7 and are zero otherwise.
// Each pixel is a read-modify-write of its store byte: a read state, then a write state,
// with a load step per line or span and a step per circle update. A clear sweeps the
// store at one byte per cycle, COLUMNS*PAGES bytes (1024 by default); a read issues the
// byte read and then registers the result. After reset the same sweep runs with busy
// high before the first command is taken.
module mono_frame_buffer_raster_engine_top
    import mfbre_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_end_x,
    input  logic [7:0] i_end_y,
    input  logic       i_ink_clear,
    output logic       o_done,
    output logic [7:0] o_read_data,
    output logic       o_off_screen
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mfbre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    mfbre_dpath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_ink_clear  (i_ink_clear),
        .o_stat       (dp_stat),
        .o_read_data  (o_read_data),
        .o_off_screen (o_off_screen)
    );

endmodule

// File: rtl/core/mfbre_checker.sv
module mfbre_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [7:0] o_read_data,
    input logic       o_off_screen
);

    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_off_screen) |-> (o_read_data == 8'd0))
        else $error("off-screen read returned data");

endmodule

bind mono_frame_buffer_raster_engine_top mfbre_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_read_data  (o_read_data),
    .o_off_screen (o_off_screen)
);
